### src/laplacian_edge_3x3_macros.svh
// ----------------------------------------------------------------------------
// laplacian_edge_3x3 assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_EDGE_3X3_MACROS_SVH
`define LAPLACIAN_EDGE_3X3_MACROS_SVH

// same-cycle implication, off during reset
`define LAP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("laplacian_edge_3x3 check failed");

// next-cycle implication, off during reset
`define LAP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("laplacian_edge_3x3 check failed");

`endif

### src/lapedge_pkg.sv
// ----------------------------------------------------------------------------
// lapedge_pkg
// shared widths, register codes and reset values of the laplacian edge filter
// ----------------------------------------------------------------------------
package lapedge_pkg;

    localparam int PIX_W      = 8;
    localparam int ROWCOL_W   = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int ENTRY_W    = 2 * PIX_W;
    localparam int RES_W      = PIX_W + 2 * ROWCOL_W;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

    localparam int MIN_DIM    = 3;
    localparam int PIX_MAX    = 255;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // one result as it sits in the output queue
    typedef struct packed {
        logic [ROWCOL_W-1:0] col;
        logic [ROWCOL_W-1:0] row;
        pix_t                value;
    } result_t;

endpackage

### src/lapedge_linebuf.sv
// ----------------------------------------------------------------------------
// lapedge_linebuf
// two-row line store in one synchronous memory, entry {upper, middle},
// registered read with forwarding of a write to the same column
// ----------------------------------------------------------------------------
module lapedge_linebuf #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [lapedge_pkg::ENTRY_W-1:0] wr_data,
    output logic [lapedge_pkg::ENTRY_W-1:0] rd_data
);
    import lapedge_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_q_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // read and write of one column in the same cycle return the new entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

### src/laplacian_edge_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_edge_3x3
// 3x3 eight-neighbour laplacian on the red channel of a raster pixel stream
// ----------------------------------------------------------------------------
// path: the request that completes a window is registered into stage 1 with its
//   line store read, then filtered into the output queue that drives m_
// throughput: one pixel per cycle while the output queue has room for results
// reset: synchronous active-low aresetn clears counters, window and queue,
//   loads width 640 and height 480; line store contents stay undefined
// ----------------------------------------------------------------------------
module laplacian_edge_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lapedge_pkg::PIX_W-1:0]     s_tdata,      // red
    input  logic                              s_tuser,      // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lapedge_pkg::M_TDATA_W-1:0] m_tdata,      // edge_value, centre_row, centre_col
    input  logic                              cfg_wr_en,
    input  logic [lapedge_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [lapedge_pkg::CFG_W-1:0]     cfg_wr_data
);
    import lapedge_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int WDW_MIN = $clog2(MAX_WIDTH + 1);
    localparam int HDW_MIN = $clog2(MAX_HEIGHT + 1);
    localparam int WDW     = (WDW_MIN > CFG_W) ? WDW_MIN : CFG_W;
    localparam int HDW     = (HDW_MIN > CFG_W) ? HDW_MIN : CFG_W;
    localparam int ACC_W   = PIX_W + 4;

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [WDW-1:0]   width_ext, width_eff;
    logic [HDW-1:0]   height_ext, height_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign width_ext  = WDW'(width_reg);
    assign height_ext = HDW'(height_reg);

    always_comb begin
        if (width_ext < WDW'(MIN_DIM)) begin
            width_eff = WDW'(MIN_DIM);
        end else if (width_ext > WDW'(MAX_WIDTH)) begin
            width_eff = WDW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (height_ext < HDW'(MIN_DIM)) begin
            height_eff = HDW'(MIN_DIM);
        end else if (height_ext > HDW'(MAX_HEIGHT)) begin
            height_eff = HDW'(MAX_HEIGHT);
        end else begin
            height_eff = height_ext;
        end
    end

    // position counters, stage 0
    logic [CW-1:0] col_reg, col_next, cur_col;
    logic [RW-1:0] row_reg, row_next, cur_row;
    logic          col_last, row_last, in_req;

    // stage 1: pixel with its line store entry
    logic          p1_valid_reg, p1_res_reg, p1_go;
    logic [CW-1:0] p1_col_reg;
    logic [RW-1:0] p1_row_reg;
    pix_t          p1_px_reg;

    // output queue
    result_t       q_reg [2];
    logic          q_head_reg;
    logic [1:0]    q_cnt_reg;
    logic          q_push, q_pop;

    assign p1_go    = p1_valid_reg && (!p1_res_reg || !q_cnt_reg[1]);
    assign s_tready = !p1_valid_reg || p1_go;
    assign in_req   = s_tvalid && s_tready;

    assign cur_col  = s_tuser ? '0 : col_reg;
    assign cur_row  = s_tuser ? '0 : row_reg;
    assign col_last = (WDW'(cur_col) + WDW'(1)) >= width_eff;
    assign row_last = (HDW'(cur_row) + HDW'(1)) >= height_eff;

    always_comb begin
        col_next = cur_col + CW'(1);
        row_next = cur_row;
        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : cur_row + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p1_res_reg   <= 1'b0;
        end else begin
            if (in_req) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                p1_valid_reg <= 1'b1;
                p1_res_reg   <= (cur_row >= RW'(2)) && (cur_col >= CW'(2));
            end else if (p1_go) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_req) begin
            p1_col_reg <= cur_col;
            p1_row_reg <= cur_row;
            p1_px_reg  <= s_tdata;
        end
    end

    // line store
    logic [ENTRY_W-1:0] lb_rd_data;
    pix_t               lb_up, lb_mid;

    lapedge_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_req),
        .rd_addr (cur_col),
        .wr_en   (p1_go),
        .wr_addr (p1_col_reg),
        .wr_data ({lb_mid, p1_px_reg}),
        .rd_data (lb_rd_data)
    );

    assign lb_up  = lb_rd_data[ENTRY_W-1:PIX_W];
    assign lb_mid = lb_rd_data[PIX_W-1:0];

    // window: two older columns kept, the newest comes from the line store and the stage 1 pixel
    pix_t win_reg [3][2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
        end else if (p1_go) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
            end
            win_reg[0][1] <= lb_up;
            win_reg[1][1] <= lb_mid;
            win_reg[2][1] <= p1_px_reg;
        end
    end

    // kernel: 8 * centre minus the eight neighbours, clamped to pixel range
    logic [PIX_W+2:0]        nb_sum;
    logic signed [ACC_W-1:0] acc;
    pix_t                    edge_val;
    logic [RW:0]             row_m1;
    logic [CW:0]             col_m1;
    result_t                 res;

    always_comb begin
        nb_sum = (PIX_W+3)'(win_reg[0][0]) + (PIX_W+3)'(win_reg[0][1])
               + (PIX_W+3)'(lb_up)        + (PIX_W+3)'(win_reg[1][0])
               + (PIX_W+3)'(lb_mid)       + (PIX_W+3)'(win_reg[2][0])
               + (PIX_W+3)'(win_reg[2][1]) + (PIX_W+3)'(p1_px_reg);
        acc = signed'(ACC_W'({win_reg[1][1], 3'b000})) - signed'(ACC_W'(nb_sum));
        if (acc < 0) begin
            edge_val = '0;
        end else if (acc > ACC_W'(PIX_MAX)) begin
            edge_val = PIX_W'(PIX_MAX);
        end else begin
            edge_val = acc[PIX_W-1:0];
        end
        row_m1    = (RW+1)'(p1_row_reg) - (RW+1)'(1);
        col_m1    = (CW+1)'(p1_col_reg) - (CW+1)'(1);
        res.value = edge_val;
        res.row   = ROWCOL_W'(row_m1);
        res.col   = ROWCOL_W'(col_m1);
    end

    // two-entry result queue keeps s_tready off the m_tready path
    assign q_push = p1_go && p1_res_reg;
    assign q_pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_head_reg <= 1'b0;
            q_cnt_reg  <= '0;
        end else begin
            if (q_pop) begin
                q_head_reg <= ~q_head_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            q_reg[q_head_reg ^ q_cnt_reg[0]] <= res;
        end
    end

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = M_TDATA_W'(q_reg[q_head_reg]);

endmodule

### src/lapedge_checker.sv
// ----------------------------------------------------------------------------
// lapedge_checker
// port-level checks of the laplacian edge filter, bound to the top level
// ----------------------------------------------------------------------------
`include "laplacian_edge_3x3_macros.svh"

module lapedge_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lapedge_pkg::M_TDATA_W-1:0] m_tdata       // edge_value, centre_row, centre_col
);
    import lapedge_pkg::*;

    logic in_req;
    assign in_req = s_tvalid && s_tready;

    // a stalled result holds
    `LAP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a new result traces back to the request that completed its window
    `LAP_ASSERT_IMPL(a_out_origin, aclk, aresetn, $rose(m_tvalid), $past(in_req, 2))

    // a draining output side never throttles the input
    `LAP_ASSERT_IMPL(a_in_ready, aclk, aresetn, $past(m_tready), s_tready)

    // results only ever belong to interior centre pixels
    `LAP_ASSERT_IMPL(a_centre_interior, aclk, aresetn, m_tvalid, (m_tdata[PIX_W +: ROWCOL_W] != '0) && (m_tdata[PIX_W+ROWCOL_W +: ROWCOL_W] != '0))

endmodule

bind laplacian_edge_3x3 lapedge_checker u_lapedge_checker (.*);
